// ===== rtl/core/bbcm_pkg.sv =====
`default_nettype none
package bbcm_pkg;
  localparam int COUNT_BITS     = 48;
  localparam int FIELD_BITS     = 48;
  localparam int CKPT_BITS      = 64;
  localparam int FIRST_BITS     = 24;
  localparam int GROWTH_BITS    = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int BIAS_BITS      = 32;
  localparam int DIV_STEPS      = 31;
  localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_CHECKPOINT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GROWTH_FACTOR    = 2'd1;

  localparam logic [FIRST_BITS-1:0]  FIRST_RESET  = 24'd1000;
  localparam logic [GROWTH_BITS-1:0] GROWTH_RESET = 32'd1351760868;

  typedef struct packed {
    logic load;
    logic step;
    logic div_run;
    logic pend_take;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic last_bit;
    logic div_done;
    logic pend_valid;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

// ===== rtl/core/bbcm_if.sv =====
`default_nettype none
interface bbcm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface bbcm_result_if;
  logic        valid;
  logic        ready;
  logic [47:0] bits_seen;
  logic [47:0] ones_seen;
  logic [31:0] bias_fraction;
  logic [2:0]  bit_position;
  logic        last_of_run;
  modport source (output valid, output bits_seen, output ones_seen, output bias_fraction,
                  output bit_position, output last_of_run, input ready);
  modport sink (input valid, input bits_seen, input ones_seen, input bias_fraction,
                input bit_position, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bbcm_controller.sv =====
`default_nettype none
module bbcm_controller (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  bbcm_pkg::status_t status,
  output bbcm_pkg::cmd_t    cmd
);
  import bbcm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_STEP, S_DIV, S_RESOLVE, S_FLUSH} state_t;
  state_t state;
  logic   was_last;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:    cmd.load = in_valid;
      S_STEP:    cmd.step = 1'b1;
      S_DIV:     cmd.div_run = 1'b1;
      S_RESOLVE: cmd.pend_take = !(status.pend_valid && status.out_busy);
      S_FLUSH:   cmd.flush = status.pend_valid && !status.out_busy;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      was_last <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_STEP;
        S_STEP: begin
          was_last <= status.last_bit;
          if (status.hit) state <= S_DIV;
          else if (status.last_bit) state <= S_FLUSH;
        end
        S_DIV: if (status.div_done) state <= S_RESOLVE;
        S_RESOLVE: if (cmd.pend_take) state <= was_last ? S_FLUSH : S_STEP;
        S_FLUSH: if (!status.pend_valid || cmd.flush) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bbcm_datapath.sv =====
`default_nettype none
module bbcm_datapath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_write,
  input  wire  [bbcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [bbcm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire  [7:0]                          in_byte,
  input  bbcm_pkg::cmd_t                      cmd,
  output bbcm_pkg::status_t                   status,
  input  wire                                 out_ready,
  output logic                                out_valid,
  output logic [bbcm_pkg::FIELD_BITS-1:0]     out_bits,
  output logic [bbcm_pkg::FIELD_BITS-1:0]     out_ones,
  output logic [bbcm_pkg::BIAS_BITS-1:0]      out_bias,
  output logic [2:0]                          out_pos,
  output logic                                out_last
);
  import bbcm_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [GROWTH_BITS-1:0]  growth;
  logic [CKPT_BITS-1:0]    ckpt;
  logic [COUNT_BITS-1:0]   bit_total, one_total;
  logic [7:0]              byte_sr;
  logic [2:0]              idx;

  logic [COUNT_BITS-1:0]   bits_next, ones_next;
  logic [CKPT_BITS:0]      need;
  logic [COUNT_BITS:0]     twice_ones, diff;

  // Division and checkpoint growth.
  logic [COUNT_BITS:0]     rem;
  logic [COUNT_BITS+1:0]   rem_sh;
  logic [DIV_STEPS-1:0]    quo;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [63:0]             ph, plw;
  logic [64:0]             grow_sum;
  logic [CKPT_BITS-1:0]    grown;

  // Result being computed and one pending result.
  logic [COUNT_BITS-1:0]   res_bits, res_ones;
  logic [2:0]              res_pos;
  logic                    res_all;
  logic [FIELD_BITS-1:0]   pend_bits, pend_ones;
  logic [BIAS_BITS-1:0]    pend_bias, res_bias;
  logic [2:0]              pend_pos;
  logic                    pend_valid;

  always_comb begin
    ones_next  = (byte_sr[idx] && one_total != COUNT_MAX) ? one_total + 1'b1 : one_total;
    bits_next  = (bit_total != COUNT_MAX) ? bit_total + 1'b1 : bit_total;
    need       = {1'b0, 16'd0, ckpt[CKPT_BITS-1:16]} + (CKPT_BITS+1)'(ckpt[15:0] != 16'd0);
    twice_ones = {ones_next, 1'b0};
    diff       = (twice_ones >= {1'b0, bits_next}) ? twice_ones - {1'b0, bits_next}
                                                   : {1'b0, bits_next} - twice_ones;
    rem_sh     = {rem, 1'b0};
    grow_sum   = {1'b0, ph[61:0], 2'b00} + 65'(plw[63:30]);
    grown      = (ph[63:62] != 2'b00 || grow_sum[64]) ? '1 : grow_sum[63:0];
    res_bias   = res_all ? {1'b1, {(BIAS_BITS-1){1'b0}}} : {1'b0, quo};
  end

  assign status.hit        = (CKPT_BITS+1)'(bits_next) >= need;
  assign status.last_bit   = (idx == 3'd7);
  assign status.div_done   = (div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1));
  assign status.pend_valid = pend_valid;
  assign status.out_busy   = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      growth     <= GROWTH_RESET;
      ckpt       <= CKPT_BITS'(FIRST_RESET) << 16;
      bit_total  <= '0;
      one_total  <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      div_cnt    <= '0;
    end else begin
      if (cfg_write && cfg_index == REG_FIRST_CHECKPOINT) begin
        ckpt <= CKPT_BITS'(cfg_data[FIRST_BITS-1:0]) << 16;
      end
      if (cfg_write && cfg_index == REG_GROWTH_FACTOR) begin
        growth <= cfg_data[GROWTH_BITS-1:0];
      end
      if (cmd.load) begin
        idx <= '0;
      end
      if (cmd.step) begin
        bit_total <= bits_next;
        one_total <= ones_next;
        idx       <= idx + 3'd1;
        div_cnt   <= '0;
      end
      if (cmd.div_run) begin
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_BITS'(2)) ckpt <= grown;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.pend_take) begin
        pend_valid <= 1'b1;
        if (pend_valid) out_valid <= 1'b1;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) byte_sr <= in_byte;
    if (cmd.step) begin
      res_bits <= bits_next;
      res_ones <= ones_next;
      res_pos  <= idx;
      res_all  <= (diff == {1'b0, bits_next});
      rem      <= diff;
      quo      <= '0;
    end
    if (cmd.div_run) begin
      if (rem_sh >= {1'b0, res_bits, 1'b0} >> 1) begin
        rem <= (COUNT_BITS+1)'(rem_sh - (COUNT_BITS+2)'(res_bits));
        quo <= {quo[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= rem_sh[COUNT_BITS:0];
        quo <= {quo[DIV_STEPS-2:0], 1'b0};
      end
      if (div_cnt == DIV_CNT_BITS'(0)) ph  <= {32'd0, ckpt[63:32]} * {32'd0, growth};
      if (div_cnt == DIV_CNT_BITS'(1)) plw <= {32'd0, ckpt[31:0]} * {32'd0, growth};
    end
    if ((cmd.pend_take && pend_valid) || cmd.flush) begin
      out_bits <= pend_bits;
      out_ones <= pend_ones;
      out_bias <= pend_bias;
      out_pos  <= pend_pos;
      out_last <= cmd.flush;
    end
    if (cmd.pend_take) begin
      pend_bits <= FIELD_BITS'(res_bits);
      pend_ones <= FIELD_BITS'(res_ones);
      pend_bias <= res_bias;
      pend_pos  <= res_pos;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bit_bias_checkpoint_monitor_unit.sv =====
`default_nettype none
// Bit bias checkpoint monitor.
// Bytes arrive on the feed channel and are examined one bit per cycle
// while no checkpoint is reached, least significant bit first, so a byte
// that reaches no checkpoint passes through acceptance, one step per bit
// and the final hand-off check. The unit keeps a bit count and a one count,
// both saturating. When the bit count reaches the current checkpoint, a
// result word is produced on the result channel with both counts, the bias
// |1/2 - ones/bits| in Q0.32 and the bit position within the byte. The
// bias comes from a restoring divider that retires one quotient bit per
// cycle, so each checkpoint adds a divider run and a hand-off state while
// the receiver keeps up; the checkpoint is multiplied by the Q2.30 growth
// factor in two 32 by 32 bit partial products during the divider run.
// One computed result is held back until the unit knows whether the byte
// causes another one, so last_of_run marks the final word of each byte.
// A stalled receiver holds the output register; the unit then waits at
// its next result without losing anything, and feed.ready stays low
// until the byte is finished.
// Synchronous reset clears the counts, restores the default registers and
// reloads the checkpoint. Configuration is written through cfg_write,
// cfg_index and cfg_data; writing the first checkpoint also reloads the
// live checkpoint.
module bit_bias_checkpoint_monitor_unit (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_write,
  input  wire  [bbcm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [bbcm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  bbcm_byte_if.sink                           feed,
  bbcm_result_if.source                       result
);
  import bbcm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller sequences bits, division and result hand-off.
  bbcm_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_ready (feed.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds counts, checkpoint, divider and result registers.
  bbcm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (feed.data_byte),
    .cmd       (cmd),
    .status    (status),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_bits  (result.bits_seen),
    .out_ones  (result.ones_seen),
    .out_bias  (result.bias_fraction),
    .out_pos   (result.bit_position),
    .out_last  (result.last_of_run)
  );
endmodule
`default_nettype wire

// ===== rtl/core/bbcm_checker.sv =====
`default_nettype none
module bbcm_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [47:0] bits_seen,
  input wire [47:0] ones_seen,
  input wire [31:0] bias_fraction
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bits_seen))
    else $error("result word changed while stalled");

  a_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ones_seen <= bits_seen)
    else $error("one count above bit count");

  a_bias: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bias_fraction <= 32'h8000_0000)
    else $error("bias above one half");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("byte accepted while previous byte in progress");
endmodule

bind bit_bias_checkpoint_monitor_unit bbcm_checker u_bbcm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (feed.valid),
  .in_ready      (feed.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .bits_seen     (result.bits_seen),
  .ones_seen     (result.ones_seen),
  .bias_fraction (result.bias_fraction)
);
`default_nettype wire
